### design/qcli_pkg.sv
package qcli_pkg;

  localparam int COORD_W = 16;
  localparam int DPROD_W = 32;
  localparam int PROD_W  = 48;
  localparam int NUM_W   = 50;
  localparam int DET_W   = 33;
  localparam int ADET_W  = 32;
  localparam int QUO_W   = 17;
  localparam int REM_W   = 51;
  localparam int DSH_W   = 48;
  localparam int BIT_W   = 5;
  localparam int LIMIT_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int OP_W    = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd128;
  localparam logic               REG_PARALLEL_LIMIT = 1'b0;

  localparam logic [QUO_W-1:0] Q_POS_MAX = 17'd32767;
  localparam logic [QUO_W-1:0] Q_NEG_MAX = 17'd32768;
  localparam logic [BIT_W-1:0] DIV_TOP   = 5'd16;

  // multiply-accumulate sequence for one corner
  localparam logic [OP_W-1:0] OP_UV    = 4'd0;
  localparam logic [OP_W-1:0] OP_VU    = 4'd1;
  localparam logic [OP_W-1:0] OP_UU    = 4'd2;
  localparam logic [OP_W-1:0] OP_VV    = 4'd3;
  localparam logic [OP_W-1:0] OP_NX0   = 4'd4;
  localparam logic [OP_W-1:0] OP_NX1   = 4'd5;
  localparam logic [OP_W-1:0] OP_NX2   = 4'd6;
  localparam logic [OP_W-1:0] OP_NX3   = 4'd7;
  localparam logic [OP_W-1:0] OP_NY0   = 4'd8;
  localparam logic [OP_W-1:0] OP_NY1   = 4'd9;
  localparam logic [OP_W-1:0] OP_NY2   = 4'd10;
  localparam logic [OP_W-1:0] OP_NY3   = 4'd11;
  localparam logic [OP_W-1:0] OP_DRAIN = 4'd12;

  typedef struct packed {
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } line_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] corner_x;
    logic signed [COORD_W-1:0] corner_y;
    logic [1:0]                corner_number;
    logic                      parallel;
    logic                      saturated;
    logic                      last;
  } corner_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_MUL,
    ST_DET,
    ST_ABS,
    ST_PAR,
    ST_DABS,
    ST_DSUM,
    ST_DOVF,
    ST_DIV,
    ST_DFIN,
    ST_EMIT
  } state_t;

endpackage

### design/quad_corner_line_intersect_core.sv
// Lines 1 .. NUM_EDGES-1 of a run: accepted while idle, with no result.
// Final line: the corners are then solved one at a time, each with a 13-step shared
// multiply sequence and, unless the lines are parallel, a 17-step divider run twice.
// The input stalls until the run's last corner is loaded, waiting out output stalls.
// Reset (rst_n low, synchronous): sequencer idle, counts and output valid cleared,
// parallel_limit back to 128; the line store is not cleared.
module quad_corner_line_intersect_core
  import qcli_pkg::*;
#(
  parameter int NUM_EDGES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // line requests
  input  logic              in_valid,
  output logic              in_stall,
  input  line_t             in_data,
  // corner requests
  output logic              out_valid,
  input  logic              out_stall,
  output corner_t           out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(NUM_EDGES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_EDGES - 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [IDX_W-1:0]     fill_r;       // lines held in the current run
  logic [IDX_W-1:0]     corner_r;     // corner being solved
  logic [OP_W-1:0]      op_r;         // multiply step
  logic [OP_W-1:0]      prod_op_r;    // step that produced prod_r
  logic [BIT_W-1:0]     bit_r;        // divider quotient bit
  logic                 out_valid_r;
  corner_t              out_data_r;

  // line store: written on accept, read one entry a cycle
  line_t                line_mem [NUM_EDGES];
  line_t                rd_data_r;
  line_t                la_r, lb_r;   // line k and line k+1

  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DPROD_W-1:0] dpa_r, dpb_r, dpc_r, dpd_r;
  logic signed [NUM_W-1:0]   nx_r, ny_r;
  logic signed [DET_W-1:0]   det_r;
  logic [ADET_W-1:0]         adet_r;
  logic                      dneg_r;
  logic                      par_r;
  logic                      sel_y_r;  // second division of the corner
  logic                      nneg_r;
  logic [NUM_W-1:0]          an_r;
  logic [REM_W-1:0]          rem_r;
  logic [DSH_W-1:0]          dsh_r;
  logic                      ovf_r;
  logic [QUO_W-1:0]          q_r;
  logic [COORD_W-1:0]        cx_r, cy_r;
  logic                      sat_r;

  // ---------------------------------------------------------------------------
  // Control outputs of the sequencer
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             out_load;
  logic [IDX_W-1:0] next_idx;
  logic             par_now;
  logic             run_done;

  assign next_idx = (corner_r == LAST_IDX) ? '0 : corner_r + 1'b1;
  assign par_now  = (adet_r == '0) || (adet_r < {{(ADET_W-LIMIT_W){1'b0}}, limit_r});
  assign run_done = in_acc && (fill_r == LAST_IDX);

  // ---------------------------------------------------------------------------
  // Register port. The one register answers at byte addresses 0-3; 4-7 read as zero.
  // ---------------------------------------------------------------------------
  logic reg_idx;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_PARALLEL_LIMIT) ?
                   {{(DATA_W-LIMIT_W){1'b0}}, limit_r} : '0;

  // ---------------------------------------------------------------------------
  // Shared multiplier: 32 x 16 signed, registered.
  // Steps 0-3 form the direction products A=u0*v1, B=v0*u1, C=u0*u1, D=v0*v1;
  // steps 4-11 accumulate
  //   nx = x1*A - x0*B - y1*C + y0*C
  //   ny = x1*D - y1*B - x0*D + y0*A
  // and each product is folded in the cycle after it is formed.
  // ---------------------------------------------------------------------------
  logic signed [DPROD_W-1:0] mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_UV: begin
        mul_a = DPROD_W'(la_r.dir_x);
        mul_b = lb_r.dir_y;
      end
      OP_VU: begin
        mul_a = DPROD_W'(la_r.dir_y);
        mul_b = lb_r.dir_x;
      end
      OP_UU: begin
        mul_a = DPROD_W'(la_r.dir_x);
        mul_b = lb_r.dir_x;
      end
      OP_VV: begin
        mul_a = DPROD_W'(la_r.dir_y);
        mul_b = lb_r.dir_y;
      end
      OP_NX0: begin
        mul_a = dpa_r;
        mul_b = lb_r.point_x;
      end
      OP_NX1: begin
        mul_a = dpb_r;
        mul_b = la_r.point_x;
      end
      OP_NX2: begin
        mul_a = dpc_r;
        mul_b = lb_r.point_y;
      end
      OP_NX3: begin
        mul_a = dpc_r;
        mul_b = la_r.point_y;
      end
      OP_NY0: begin
        mul_a = dpd_r;
        mul_b = lb_r.point_x;
      end
      OP_NY1: begin
        mul_a = dpb_r;
        mul_b = lb_r.point_y;
      end
      OP_NY2: begin
        mul_a = dpd_r;
        mul_b = la_r.point_x;
      end
      OP_NY3: begin
        mul_a = dpa_r;
        mul_b = la_r.point_y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = $signed({{(PROD_W-DPROD_W){mul_a[DPROD_W-1]}}, mul_a}) *
                 $signed({{(PROD_W-COORD_W){mul_b[COORD_W-1]}}, mul_b});

  // accumulator: one adder shared by nx and ny
  logic                    acc_is_y, acc_first, acc_sub;
  logic signed [NUM_W-1:0] acc_base, acc_prod, acc_sum;

  assign acc_is_y  = (prod_op_r == OP_NY0) || (prod_op_r == OP_NY1) ||
                     (prod_op_r == OP_NY2) || (prod_op_r == OP_NY3);
  assign acc_first = (prod_op_r == OP_NX0) || (prod_op_r == OP_NY0);
  assign acc_sub   = (prod_op_r == OP_NX1) || (prod_op_r == OP_NX2) ||
                     (prod_op_r == OP_NY1) || (prod_op_r == OP_NY2);
  assign acc_base  = acc_first ? '0 : (acc_is_y ? ny_r : nx_r);
  assign acc_prod  = {{(NUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_sum   = acc_sub ? (acc_base - acc_prod) : (acc_base + acc_prod);

  // ---------------------------------------------------------------------------
  // Divider helpers. The quotient is rounded half away from zero by adding
  // |det|/2 to |num| first; a dividend of |det|<<17 or more is out of range.
  // ---------------------------------------------------------------------------
  logic signed [DET_W-1:0] det_neg;
  logic signed [NUM_W-1:0] num_sel;
  logic                    div_ge;
  logic [QUO_W-1:0]        q_lim, q_clip, q_neg;
  logic                    q_over;
  logic [COORD_W-1:0]      q_val;

  assign det_neg = -det_r;
  assign num_sel = sel_y_r ? ny_r : nx_r;
  assign div_ge  = (rem_r >= {{(REM_W-DSH_W){1'b0}}, dsh_r});
  assign q_lim   = nneg_r ? Q_NEG_MAX : Q_POS_MAX;
  assign q_over  = ovf_r || (q_r > q_lim);
  assign q_clip  = q_over ? q_lim : q_r;
  assign q_neg   = '0 - q_clip;
  assign q_val   = nneg_r ? q_neg[COORD_W-1:0] : q_clip[COORD_W-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (run_done) state_nxt = ST_RD_A;
      end
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: state_nxt = ST_RD_C;
      ST_RD_C: state_nxt = ST_MUL;
      ST_MUL: begin
        if (op_r == OP_DRAIN) state_nxt = ST_DET;
      end
      ST_DET:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_PAR;
      ST_PAR:  state_nxt = par_now ? ST_EMIT : ST_DABS;
      ST_DABS: state_nxt = ST_DSUM;
      ST_DSUM: state_nxt = ST_DOVF;
      ST_DOVF: state_nxt = ST_DIV;
      ST_DIV: begin
        if (bit_r == '0) state_nxt = ST_DFIN;
      end
      ST_DFIN: state_nxt = sel_y_r ? ST_EMIT : ST_DABS;
      ST_EMIT: begin
        if (out_load) state_nxt = (corner_r == LAST_IDX) ? ST_IDLE : ST_RD_A;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = corner_r;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_RD_A: rd_en = 1'b1;
      ST_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = next_idx;
      end
      // a waiting corner may leave in the same cycle the next one is loaded
      ST_EMIT: out_load = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      fill_r      <= '0;
      corner_r    <= '0;
      op_r        <= OP_UV;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (psel && penable && pwrite && pready && (reg_idx == REG_PARALLEL_LIMIT)) begin
        limit_r <= pwdata[LIMIT_W-1:0];
      end

      if (in_acc) begin
        fill_r <= (fill_r == LAST_IDX) ? '0 : fill_r + 1'b1;
      end

      if (run_done) begin
        corner_r <= '0;
      end else if (out_load && (corner_r != LAST_IDX)) begin
        corner_r <= corner_r + 1'b1;
      end

      if (state_r == ST_RD_C) begin
        op_r <= OP_UV;
      end else if (state_r == ST_MUL) begin
        op_r <= op_r + 1'b1;
      end

      if (state_r == ST_DOVF) begin
        bit_r <= DIV_TOP;
      end else if (state_r == ST_DIV) begin
        bit_r <= bit_r - 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_mem[fill_r] <= in_data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_RD_B: la_r <= rd_data_r;
      ST_RD_C: lb_r <= rd_data_r;
      ST_MUL: begin
        prod_r    <= mul_p;
        prod_op_r <= op_r;
        if (op_r != OP_UV) begin
          case (prod_op_r)
            OP_UV:   dpa_r <= prod_r[DPROD_W-1:0];
            OP_VU:   dpb_r <= prod_r[DPROD_W-1:0];
            OP_UU:   dpc_r <= prod_r[DPROD_W-1:0];
            OP_VV:   dpd_r <= prod_r[DPROD_W-1:0];
            default: begin
              if (acc_is_y) begin
                ny_r <= acc_sum;
              end else begin
                nx_r <= acc_sum;
              end
            end
          endcase
        end
      end
      ST_DET: begin
        det_r <= {dpa_r[DPROD_W-1], dpa_r} - {dpb_r[DPROD_W-1], dpb_r};
      end
      ST_ABS: begin
        dneg_r <= det_r[DET_W-1];
        adet_r <= det_r[DET_W-1] ? det_neg[ADET_W-1:0] : det_r[ADET_W-1:0];
      end
      ST_PAR: begin
        par_r   <= par_now;
        sel_y_r <= 1'b0;
        sat_r   <= 1'b0;
        cx_r    <= '0;
        cy_r    <= '0;
      end
      ST_DABS: begin
        an_r   <= num_sel[NUM_W-1] ? -num_sel : num_sel;
        nneg_r <= num_sel[NUM_W-1] ^ dneg_r;
      end
      ST_DSUM: begin
        rem_r <= {1'b0, an_r} + {{(REM_W-ADET_W+1){1'b0}}, adet_r[ADET_W-1:1]};
      end
      ST_DOVF: begin
        ovf_r <= (rem_r >= {{(REM_W-ADET_W-QUO_W){1'b0}}, adet_r, {QUO_W{1'b0}}});
        dsh_r <= {adet_r, {(DSH_W-ADET_W){1'b0}}};
        q_r   <= '0;
      end
      ST_DIV: begin
        if (div_ge) begin
          rem_r <= rem_r - {{(REM_W-DSH_W){1'b0}}, dsh_r};
        end
        q_r   <= {q_r[QUO_W-2:0], div_ge};
        dsh_r <= dsh_r >> 1;
      end
      ST_DFIN: begin
        if (sel_y_r) begin
          cy_r <= q_val;
        end else begin
          cx_r <= q_val;
        end
        sat_r   <= sat_r | q_over;
        sel_y_r <= 1'b1;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_data_r.corner_x      <= cx_r;
          out_data_r.corner_y      <= cy_r;
          out_data_r.corner_number <= corner_r[1:0];
          out_data_r.parallel      <= par_r;
          out_data_r.saturated     <= sat_r;
          out_data_r.last          <= (corner_r == LAST_IDX);
        end
      end
      default: begin
        prod_op_r <= prod_op_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/qcli_checker.sv
module qcli_checker
  import qcli_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input line_t   in_data,
  input logic    out_valid,
  input logic    out_stall,
  input corner_t out_data
);

  // a stalled corner holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("corner changed while stalled");

  // corners appear only while the block is busy with a run
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("corner appeared outside a run");

  // parallel lines give a zero corner without saturation
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.parallel |->
      out_data.corner_x == 0 && out_data.corner_y == 0 && !out_data.saturated)
    else $error("parallel corner not zero");

  // once lines are taken again, only the final corner of a run may still wait
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_stall |-> out_data.last)
    else $error("line taken before run finished");

endmodule

bind quad_corner_line_intersect_core qcli_checker u_qcli_checker (.*);

### tb/quad_corner_checker.sv
module quad_corner_checker
  import qcli_pkg::*;
#(
  parameter int                NUM_EDGES  = 4,
  parameter logic [ADDR_W-1:0] LIMIT_ADDR = '0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  line_t             in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  corner_t           out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                failures,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 50;

  line_t              side_lines [NUM_EDGES];
  int                 lines_in_run;
  logic [LIMIT_W-1:0] parallel_limit;
  corner_t            corners_due [$];

  // |num|/|den| rounded half away from zero, sign restored, clipped to Q12.4
  function automatic logic [COORD_W-1:0] round_clip(longint num, longint den,
                                                    inout logic sat);
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] q;
    logic        neg;
    an  = (num < 0) ? 64'(-num) : 64'(num);
    ad  = (den < 0) ? 64'(-den) : 64'(den);
    q   = (an + (ad >> 1)) / ad;
    neg = (num < 0) != (den < 0);
    if (neg) begin
      if (q > 64'd32768) begin
        sat = 1'b1;
        q   = 64'd32768;
      end
      q = 64'd0 - q;
    end else if (q > 64'd32767) begin
      sat = 1'b1;
      q   = 64'd32767;
    end
    return q[COORD_W-1:0];
  endfunction

  // Cramer's rule for the meeting of line a (line k) and line b (line k+1)
  function automatic corner_t solve_corner(line_t a, line_t b, int k,
                                           logic [LIMIT_W-1:0] limit);
    longint  u0, v0, x0, y0, u1, v1, x1, y1;
    longint  det, adet, nx, ny;
    corner_t c;
    logic    sat;
    u0  = a.dir_x;
    v0  = a.dir_y;
    x0  = a.point_x;
    y0  = a.point_y;
    u1  = b.dir_x;
    v1  = b.dir_y;
    x1  = b.point_x;
    y1  = b.point_y;
    c   = '0;
    sat = 1'b0;
    det  = u0 * v1 - v0 * u1;
    adet = (det < 0) ? -det : det;
    if (det == 0 || adet < longint'(limit)) begin
      c.parallel = 1'b1;
    end else begin
      nx = x1 * u0 * v1 - y1 * u0 * u1 - x0 * u1 * v0 + y0 * u0 * u1;
      ny = x1 * v0 * v1 - y1 * v0 * u1 - x0 * v0 * v1 + y0 * u0 * v1;
      c.corner_x = round_clip(nx, det, sat);
      c.corner_y = round_clip(ny, det, sat);
    end
    c.corner_number = k[1:0];
    c.saturated     = sat;
    c.last          = (k == NUM_EDGES - 1);
    return c;
  endfunction

  // printing capped so a broken block cannot flood the log
  task automatic report(string msg);
    if (failures < MAX_PRINTED)
      $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  task automatic compare_field(string name, int number, longint got, longint want);
    if (got != want)
      report($sformatf("corner %0d %s: got %0d, expected %0d", number, name, got, want));
  endtask

  task automatic check_corner(corner_t got);
    corner_t want;
    if (corners_due.size() == 0) begin
      report($sformatf("corner %0d arrived with none outstanding", got.corner_number));
      return;
    end
    want = corners_due.pop_front();
    compare_field("corner_x", want.corner_number, got.corner_x, want.corner_x);
    compare_field("corner_y", want.corner_number, got.corner_y, want.corner_y);
    compare_field("corner_number", want.corner_number, got.corner_number,
                  want.corner_number);
    compare_field("parallel", want.corner_number, got.parallel, want.parallel);
    compare_field("saturated", want.corner_number, got.saturated, want.saturated);
    compare_field("last", want.corner_number, got.last, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lines_in_run   = 0;
      parallel_limit = LIMIT_RESET;
      corners_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        parallel_limit = pwdata[LIMIT_W-1:0];
      if (out_valid && !out_stall)
        check_corner(out_data);
      if (in_valid && !in_stall) begin
        side_lines[lines_in_run] = in_data;
        lines_in_run++;
        if (lines_in_run == NUM_EDGES) begin
          lines_in_run = 0;
          for (int k = 0; k < NUM_EDGES; k++)
            corners_due.insert(corners_due.size(),
                               solve_corner(side_lines[k],
                                            side_lines[(k + 1) % NUM_EDGES],
                                            k, parallel_limit));
        end
      end
    end
    pending = corners_due.size();
  end

endmodule

### tb/quad_corner_line_intersect_core_tb.sv
module quad_corner_line_intersect_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qcli_pkg::*;

  localparam int                NUM_EDGES    = 4;
  localparam logic [ADDR_W-1:0] LIMIT_ADDR   = ADDR_W'(4 * REG_PARALLEL_LIMIT);
  // the hold-off outlasts a full run of four corners, so it is long enough for
  // the block to back up into its line input
  localparam int                HOLD_CYCLES  = 600;
  // settle time before a register write
  localparam int                DRAIN_CYCLES = 80;
  localparam real               TWO_PI       = 6.283185307179586;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  line_t             in_data;
  logic              out_valid;
  logic              out_stall;
  corner_t           out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int    failures;
  int    pending;
  int    hold_asks;   // bumped by the stimulus to ask the receiver for a hold-off
  int    burst_left;  // line requests left in the sender's current burst
  line_t quad_lines [NUM_EDGES];

  quad_corner_line_intersect_core #(.NUM_EDGES(NUM_EDGES)) dut (.*);

  quad_corner_checker #(
    .NUM_EDGES (NUM_EDGES),
    .LIMIT_ADDR(LIMIT_ADDR)
  ) u_corner_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: several times the slowest legal run.
  initial begin
    #4ms;
    $display("quad_corner_line_intersect_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls on a pattern of its own. Modes last a random number of
  // cycles: never stall, light random stall, heavy random stall, or a square
  // wave of random period. A hold-off request overrides all of it.
  // ---------------------------------------------------------------------------
  initial begin : receiver_stall
    int mode;
    int mode_left;
    int period;
    int holds_done;
    mode       = 0;
    mode_left  = 0;
    period     = 2;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        out_stall <= 1'b1;
        for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
          period    = $urandom_range(2, 9);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((mode_left % period) < (period / 2));
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Helpers for building line requests
  // ---------------------------------------------------------------------------
  function automatic logic signed [COORD_W-1:0] clip16(int v);
    if (v > 32767)  return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[COORD_W-1:0];
  endfunction

  function automatic line_t make_line(int dx, int dy, int px, int py);
    line_t l;
    l.dir_x   = clip16(dx);
    l.dir_y   = clip16(dy);
    l.point_x = clip16(px);
    l.point_y = clip16(py);
    return l;
  endfunction

  function automatic real rand_real(real lo, real hi);
    return lo + (hi - lo) * $urandom_range(0, 1_000_000) / 1.0e6;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      6:       return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: line requests go out in bursts of random length with random gaps.
  // Called and returns at a falling edge; valid is only dropped for a gap, so
  // back-to-back requests keep valid high without a glitch.
  // ---------------------------------------------------------------------------
  task automatic send_line(line_t l);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      // now and then a long burst, so there are stretches with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= l;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_quad();
    for (int k = 0; k < NUM_EDGES; k++) send_line(quad_lines[k]);
  endtask

  // Register write, only once every outstanding corner is back and the
  // sequencer has had time to settle.
  task automatic program_limit(int value);
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= LIMIT_ADDR;
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed quads
  // ---------------------------------------------------------------------------
  task automatic send_directed(int which);
    case (which)
      0: begin
        // axis-aligned square, full-scale unit directions of both signs
        quad_lines[0] = make_line( 32767,      0,    0,    0);
        quad_lines[1] = make_line(     0,  32767, 1600,    0);
        quad_lines[2] = make_line(-32768,      0, 1600, 1600);
        quad_lines[3] = make_line(     0, -32768,    0, 1600);
      end
      1: begin
        // every edge parallel, some with reversed direction
        quad_lines[0] = make_line( 23170,  23170,      0,      0);
        quad_lines[1] = make_line(-23170, -23170,    160,   -160);
        quad_lines[2] = make_line( 23170,  23170, -32768,  32767);
        quad_lines[3] = make_line( 23170,  23170,  32767, -32768);
      end
      2: begin
        // determinant exactly at the reset limit (128) and just below it (127)
        quad_lines[0] = make_line( 1,    0,  0,  0);
        quad_lines[1] = make_line( 0,  128, 16, 16);
        quad_lines[2] = make_line(-1,    0, 32, 32);
        quad_lines[3] = make_line( 0, -127, 48, 48);
      end
      3: begin
        // every field at one of its extremes
        quad_lines[0] = make_line(-32768, -32768, -32768,  32767);
        quad_lines[1] = make_line( 32767, -32768,  32767, -32768);
        quad_lines[2] = make_line(-32768,  32767, -32768, -32768);
        quad_lines[3] = make_line( 32767,  32767,  32767,  32767);
      end
      4: begin
        // nearly parallel edges far apart: the quotient clips at its negative bound
        quad_lines[0] = make_line(32767,     0,      0,      0);
        quad_lines[1] = make_line(32767,     1,      0,  16000);
        quad_lines[2] = make_line(    0, 32767,    100,    100);
        quad_lines[3] = make_line(32767,    -1, -32768, -32768);
      end
      default: begin
        // zero direction (determinant zero) and tiny non-unit directions
        quad_lines[0] = make_line(  0,  0,   80,   80);
        quad_lines[1] = make_line(100, -3, -200,   40);
        quad_lines[2] = make_line( -7,  9,  300, -300);
        quad_lines[3] = make_line(  1,  1,  -16,   16);
      end
    endcase
    send_quad();
  endtask

  // ---------------------------------------------------------------------------
  // Random quads
  // ---------------------------------------------------------------------------

  // A convex-ish quadrilateral: corners on a circle, each edge line running
  // through its two neighbouring corners so the block should land on them.
  task automatic well_formed_quad();
    real cx, cy, rad, ang, ex, ey, len, scale, t;
    real px [NUM_EDGES];
    real py [NUM_EDGES];
    int  prev;
    cx  = rand_real(-1700.0, 1700.0);
    cy  = rand_real(-1700.0, 1700.0);
    rad = rand_real(20.0, 300.0);
    ang = rand_real(0.0, TWO_PI);
    for (int k = 0; k < NUM_EDGES; k++) begin
      px[k] = cx + rad * $cos(ang);
      py[k] = cy + rad * $sin(ang);
      ang  += rand_real(0.7, 1.9);
    end
    for (int k = 0; k < NUM_EDGES; k++) begin
      prev  = (k + NUM_EDGES - 1) % NUM_EDGES;
      ex    = px[k] - px[prev];
      ey    = py[k] - py[prev];
      len   = $sqrt(ex * ex + ey * ey);
      // mostly unit length; sometimes shortened, sometimes flipped
      scale = ($urandom_range(0, 4) == 0) ? rand_real(0.05, 1.0) : 1.0;
      if ($urandom_range(0, 1) == 1) scale = -scale;
      t     = rand_real(0.0, 1.0);
      quad_lines[k] = make_line(int'(32767.0 * scale * ex / len),
                                int'(32767.0 * scale * ey / len),
                                int'(16.0 * (px[prev] + t * ex)),
                                int'(16.0 * (py[prev] + t * ey)));
    end
  endtask

  task automatic random_quads(int count);
    int kind;
    int k;
    int j;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      well_formed_quad();
      case (kind)
        6: begin
          // noise: every bit random
          for (k = 0; k < NUM_EDGES; k++) quad_lines[k] = {$urandom(), $urandom()};
        end
        7: begin
          for (k = 0; k < NUM_EDGES; k++)
            quad_lines[k] = make_line(pick_extreme(), pick_extreme(),
                                      pick_extreme(), pick_extreme());
        end
        8, 9: begin
          // neighbour copies a direction with a nudge of a few LSBs: lands the
          // determinant at zero or close to the limit
          k = $urandom_range(0, NUM_EDGES - 1);
          j = (k + 1) % NUM_EDGES;
          quad_lines[j].dir_x = quad_lines[k].dir_x;
          quad_lines[j].dir_y = clip16(quad_lines[k].dir_y +
                                       int'($urandom_range(0, 6)) - 3);
        end
        default: ;
      endcase
      send_quad();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    hold_asks  = 0;
    burst_left = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit of 128
    for (int d = 0; d < 5; d++) send_directed(d);
    random_quads(13);

    // limit 0: only an exact zero determinant counts as parallel
    program_limit(0);
    send_directed(5);
    random_quads(13);

    // largest limit, with a long receiver hold-off to back the block up
    program_limit(65535);
    hold_asks++;
    random_quads(14);

    program_limit($urandom_range(1, 65534));
    random_quads(13);

    program_limit($urandom_range(0, 300));
    hold_asks++;
    random_quads(14);

    program_limit(LIMIT_RESET);
    random_quads(13);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    if (failures == 0) begin
      $display("quad_corner_line_intersect_core test passed");
    end else begin
      $display("quad_corner_line_intersect_core test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/qcli_pkg.sv
design/quad_corner_line_intersect_core.sv
design/qcli_checker.sv
tb/quad_corner_checker.sv
tb/quad_corner_line_intersect_core_tb.sv
